[rtl/core/m4inv_pkg.sv]
// m4inv_pkg: shared types and coefficient tables for the 4x4 matrix inverter
// holds the controller/datapath command and status structs and the cofactor tables
// no dependencies
package m4inv_pkg;

    // computation phases driven by the controller
    typedef enum logic [1:0] {
        PH_SC  = 2'd0,
        PH_COF = 2'd1,
        PH_DET = 2'd2
    } m4inv_phase_t;

    // wide store layout: elements, then 2x2 sub-determinants, then adjugate
    localparam logic [5:0] WA_SC  = 6'd16;
    localparam logic [5:0] WA_COF = 6'd28;
    localparam int         WIDE_DEPTH = 44;

    // controller to datapath
    typedef struct packed {
        logic         load;
        logic         mac;
        m4inv_phase_t phase;
        logic [3:0]   idx;
        logic [1:0]   term;
        logic [1:0]   chunk;
        logic         rd_cof;
        logic         div_go;
        logic         emit;
        logic         emit_zero;
        logic [3:0]   pos;
    } m4inv_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic det_zero;
        logic div_done;
    } m4inv_status_t;

    // sub-determinant p*q - r*t, element indices
    typedef struct packed {
        logic [3:0] p;
        logic [3:0] q;
        logic [3:0] r;
        logic [3:0] t;
    } m4inv_sc_term_t;

    // one adjugate term: element times sub-determinant, with sign
    typedef struct packed {
        logic       neg;
        logic [3:0] sc;
        logic [3:0] e;
    } m4inv_cof_term_t;

    // s0..s5 from rows 0 and 1, c0..c5 (codes 6..11) from rows 2 and 3
    function automatic m4inv_sc_term_t sc_term(input logic [3:0] idx);
        m4inv_sc_term_t r;
        begin
            case (idx)
                4'd0:    r = '{4'd0,  4'd5,  4'd1,  4'd4};
                4'd1:    r = '{4'd0,  4'd6,  4'd2,  4'd4};
                4'd2:    r = '{4'd0,  4'd7,  4'd3,  4'd4};
                4'd3:    r = '{4'd1,  4'd6,  4'd2,  4'd5};
                4'd4:    r = '{4'd1,  4'd7,  4'd3,  4'd5};
                4'd5:    r = '{4'd2,  4'd7,  4'd3,  4'd6};
                4'd6:    r = '{4'd8,  4'd13, 4'd9,  4'd12};
                4'd7:    r = '{4'd8,  4'd14, 4'd10, 4'd12};
                4'd8:    r = '{4'd8,  4'd15, 4'd11, 4'd12};
                4'd9:    r = '{4'd9,  4'd14, 4'd10, 4'd13};
                4'd10:   r = '{4'd9,  4'd15, 4'd11, 4'd13};
                4'd11:   r = '{4'd10, 4'd15, 4'd11, 4'd14};
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // adjugate element idx (row-major) is the sum of three such terms
    function automatic m4inv_cof_term_t cof_term(input logic [3:0] idx,
                                                 input logic [1:0] term);
        m4inv_cof_term_t r;
        begin
            case ({idx, term})
                {4'd0,  2'd0}: r = '{1'b0, 4'd11, 4'd5};
                {4'd0,  2'd1}: r = '{1'b1, 4'd10, 4'd6};
                {4'd0,  2'd2}: r = '{1'b0, 4'd9,  4'd7};
                {4'd1,  2'd0}: r = '{1'b1, 4'd11, 4'd1};
                {4'd1,  2'd1}: r = '{1'b0, 4'd10, 4'd2};
                {4'd1,  2'd2}: r = '{1'b1, 4'd9,  4'd3};
                {4'd2,  2'd0}: r = '{1'b0, 4'd5,  4'd13};
                {4'd2,  2'd1}: r = '{1'b1, 4'd4,  4'd14};
                {4'd2,  2'd2}: r = '{1'b0, 4'd3,  4'd15};
                {4'd3,  2'd0}: r = '{1'b1, 4'd5,  4'd9};
                {4'd3,  2'd1}: r = '{1'b0, 4'd4,  4'd10};
                {4'd3,  2'd2}: r = '{1'b1, 4'd3,  4'd11};
                {4'd4,  2'd0}: r = '{1'b1, 4'd11, 4'd4};
                {4'd4,  2'd1}: r = '{1'b0, 4'd8,  4'd6};
                {4'd4,  2'd2}: r = '{1'b1, 4'd7,  4'd7};
                {4'd5,  2'd0}: r = '{1'b0, 4'd11, 4'd0};
                {4'd5,  2'd1}: r = '{1'b1, 4'd8,  4'd2};
                {4'd5,  2'd2}: r = '{1'b0, 4'd7,  4'd3};
                {4'd6,  2'd0}: r = '{1'b1, 4'd5,  4'd12};
                {4'd6,  2'd1}: r = '{1'b0, 4'd2,  4'd14};
                {4'd6,  2'd2}: r = '{1'b1, 4'd1,  4'd15};
                {4'd7,  2'd0}: r = '{1'b0, 4'd5,  4'd8};
                {4'd7,  2'd1}: r = '{1'b1, 4'd2,  4'd10};
                {4'd7,  2'd2}: r = '{1'b0, 4'd1,  4'd11};
                {4'd8,  2'd0}: r = '{1'b0, 4'd10, 4'd4};
                {4'd8,  2'd1}: r = '{1'b1, 4'd8,  4'd5};
                {4'd8,  2'd2}: r = '{1'b0, 4'd6,  4'd7};
                {4'd9,  2'd0}: r = '{1'b1, 4'd10, 4'd0};
                {4'd9,  2'd1}: r = '{1'b0, 4'd8,  4'd1};
                {4'd9,  2'd2}: r = '{1'b1, 4'd6,  4'd3};
                {4'd10, 2'd0}: r = '{1'b0, 4'd4,  4'd12};
                {4'd10, 2'd1}: r = '{1'b1, 4'd2,  4'd13};
                {4'd10, 2'd2}: r = '{1'b0, 4'd0,  4'd15};
                {4'd11, 2'd0}: r = '{1'b1, 4'd4,  4'd8};
                {4'd11, 2'd1}: r = '{1'b0, 4'd2,  4'd9};
                {4'd11, 2'd2}: r = '{1'b1, 4'd0,  4'd11};
                {4'd12, 2'd0}: r = '{1'b1, 4'd9,  4'd4};
                {4'd12, 2'd1}: r = '{1'b0, 4'd7,  4'd5};
                {4'd12, 2'd2}: r = '{1'b1, 4'd6,  4'd6};
                {4'd13, 2'd0}: r = '{1'b0, 4'd9,  4'd0};
                {4'd13, 2'd1}: r = '{1'b1, 4'd7,  4'd1};
                {4'd13, 2'd2}: r = '{1'b0, 4'd6,  4'd2};
                {4'd14, 2'd0}: r = '{1'b1, 4'd3,  4'd12};
                {4'd14, 2'd1}: r = '{1'b0, 4'd1,  4'd13};
                {4'd14, 2'd2}: r = '{1'b1, 4'd0,  4'd14};
                {4'd15, 2'd0}: r = '{1'b0, 4'd3,  4'd8};
                {4'd15, 2'd1}: r = '{1'b1, 4'd1,  4'd9};
                {4'd15, 2'd2}: r = '{1'b0, 4'd0,  4'd10};
                default:       r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

[rtl/core/m4inv_div.sv]
// m4inv_div: restoring divider for one inverse element, rounded and saturated
// quotient = round(|cofactor| * 2^(2F) / |det|), one quotient bit per cycle
// no package dependencies
module m4inv_div #(
    parameter int W   = 32,
    parameter int F   = 16,
    parameter int VW  = 4 * W + 1,
    parameter int DTW = 4 * W + 3
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [VW-1:0]  num,
    input  logic signed [DTW-1:0] den,
    output logic                  done,
    output logic [W-1:0]          quot,
    output logic                  sat
);

    localparam int RW = (VW + 2 * F + 1 > DTW + W + 2) ? VW + 2 * F + 1 : DTW + W + 2;
    localparam int QW = W + 2;
    localparam int CW = $clog2(W + 2);

    logic          busy_reg, busy_next;
    logic          first_reg, first_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [RW-1:0] rem_reg;
    logic [RW-1:0] dsh_reg;
    logic [QW-1:0] q_reg;
    logic          neg_reg;
    logic          ovf_reg;

    logic [VW-1:0]  nabs;
    logic [DTW-1:0] dabs;
    logic           ge;
    logic [RW-1:0]  diff;
    logic [QW-1:0]  qr, lim, mag, sval;

    // magnitudes and one restoring step
    assign nabs = num[VW-1] ? -num : num;
    assign dabs = den[DTW-1] ? -den : den;
    assign ge   = rem_reg >= dsh_reg;
    assign diff = rem_reg - dsh_reg;

    // step sequencing
    always_comb
    begin
        busy_next  = busy_reg;
        first_next = first_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        if (start)
        begin
            busy_next  = 1'b1;
            first_next = 1'b1;
            cnt_next   = CW'(W + 1);
        end
        else if (busy_reg)
        begin
            if (first_reg)
            begin
                first_next = 1'b0;
            end
            else if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            first_reg <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            first_reg <= first_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    // remainder, shifted divisor and quotient bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= RW'(nabs) << (2 * F + 1);
            dsh_reg <= RW'(dabs) << (W + 2);
            neg_reg <= num[VW-1] ^ den[DTW-1];
            q_reg   <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            dsh_reg <= dsh_reg >> 1;
            if (first_reg)
            begin
                // quotient too large for the kept bits
                ovf_reg <= ge;
            end
            else
            begin
                if (ge)
                begin
                    rem_reg <= diff;
                end
                q_reg <= {q_reg[QW-2:0], ge};
            end
        end
    end

    // round half away from zero, then clip
    assign qr   = {1'b0, q_reg[QW-1:1]} + QW'(q_reg[0]);
    assign lim  = (QW'(1) << (W - 1)) - QW'(!neg_reg);
    assign sat  = ovf_reg | (qr > lim);
    assign mag  = sat ? lim : qr;
    assign sval = neg_reg ? -mag : mag;
    assign quot = sval[W-1:0];
    assign done = done_reg;

endmodule

[rtl/core/m4inv_dp.sv]
// m4inv_dp: datapath of the matrix inverter
// element and wide value stores, multiply-accumulate pipeline, divider, result registers
// depends on m4inv_pkg and m4inv_div
module m4inv_dp #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  m4inv_pkg::m4inv_cmd_t    cmd,
    input  logic signed [W-1:0]  element_in,
    output m4inv_pkg::m4inv_status_t status,
    output logic                 result_strobe,
    output logic signed [W-1:0]  element_out,
    output logic [3:0]           position,
    output logic                 last_element,
    output logic                 singular,
    output logic                 saturated
);
    import m4inv_pkg::*;

    localparam int VW  = 4 * W + 1;
    localparam int AW  = 5 * W + 2;
    localparam int DTW = 4 * W + 3;

    typedef struct packed {
        logic       v;
        logic [1:0] chunk;
        logic       top;
        logic       neg;
        logic       first;
        logic       wr;
        logic       wr_det;
        logic [5:0] dst;
    } mac_ctl_t;

    logic [W-1:0]  elem_mem [16];
    logic [VW-1:0] wide_mem [WIDE_DEPTH];

    logic [3:0]        ea;
    logic [5:0]        wa;
    mac_ctl_t          ctl0;
    mac_ctl_t          s1_reg, s2_reg;
    m4inv_sc_term_t    sct;
    m4inv_cof_term_t   cft;

    logic signed [W-1:0]   e_rd_reg;
    logic [VW-1:0]         w_rd_reg;
    logic signed [W:0]     opb;
    logic signed [2*W:0]   ea_x, ob_x, prod_next, prod_reg;
    logic signed [AW-1:0]  prod_ext, shifted, addend, acc_next, acc_reg;
    logic signed [DTW-1:0] det_reg;

    logic         div_done;
    logic [W-1:0] div_q;
    logic         div_sat;

    logic         strobe_reg;
    logic [W-1:0] elem_out_reg;
    logic [3:0]   pos_reg;
    logic         last_reg, sing_reg, sat_reg;

    // operand addresses and pipeline control from the command
    always_comb
    begin
        sct  = sc_term(cmd.idx);
        cft  = cof_term(cmd.idx, cmd.term);
        ea   = '0;
        wa   = '0;
        ctl0 = '0;
        unique case (cmd.phase)
            PH_SC:
            begin
                ea         = cmd.term[0] ? sct.r : sct.p;
                wa         = {2'b00, cmd.term[0] ? sct.t : sct.q};
                ctl0.top   = 1'b1;
                ctl0.neg   = cmd.term[0];
                ctl0.first = !cmd.term[0];
                ctl0.wr    = cmd.term[0];
                ctl0.dst   = WA_SC + {2'b00, cmd.idx};
            end
            PH_COF:
            begin
                ea         = cft.e;
                wa         = WA_SC + {2'b00, cft.sc};
                ctl0.chunk = cmd.chunk;
                ctl0.top   = cmd.chunk == 2'd1;
                ctl0.neg   = cft.neg;
                ctl0.first = (cmd.term == 2'd0) && (cmd.chunk == 2'd0);
                ctl0.wr    = (cmd.term == 2'd2) && (cmd.chunk == 2'd1);
                ctl0.dst   = WA_COF + {2'b00, cmd.idx};
            end
            PH_DET:
            begin
                ea          = cmd.idx;
                wa          = WA_COF + {2'b00, cmd.idx[1:0], 2'b00};
                ctl0.chunk  = cmd.chunk;
                ctl0.top    = cmd.chunk == 2'd3;
                ctl0.first  = (cmd.idx == 4'd0) && (cmd.chunk == 2'd0);
                ctl0.wr_det = (cmd.idx == 4'd3) && (cmd.chunk == 2'd3);
            end
            default:
            begin
                ea = '0;
            end
        endcase
        ctl0.v = cmd.mac;
        if (cmd.rd_cof)
        begin
            wa = WA_COF + {2'b00, cmd.pos};
        end
    end

    // stores: elements written on load, wide values on load or writeback, registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            elem_mem[cmd.idx] <= element_in;
        end
        e_rd_reg <= elem_mem[ea];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            wide_mem[{2'b00, cmd.idx}] <= {{(VW-W){element_in[W-1]}}, element_in};
        end
        else if (s2_reg.v && s2_reg.wr)
        begin
            wide_mem[s2_reg.dst] <= acc_next[VW-1:0];
        end
        w_rd_reg <= wide_mem[wa];
    end

    // chunk of the wide operand, top chunk signed
    always_comb
    begin
        case (s1_reg.chunk)
            2'd0:    opb = s1_reg.top ? $signed(w_rd_reg[W:0])
                                      : $signed({1'b0, w_rd_reg[W-1:0]});
            2'd1:    opb = s1_reg.top ? $signed(w_rd_reg[2*W:W])
                                      : $signed({1'b0, w_rd_reg[2*W-1:W]});
            2'd2:    opb = $signed({1'b0, w_rd_reg[3*W-1:2*W]});
            default: opb = $signed(w_rd_reg[4*W:3*W]);
        endcase
    end

    assign ea_x      = {{(W+1){e_rd_reg[W-1]}}, e_rd_reg};
    assign ob_x      = {{W{opb[W]}}, opb};
    assign prod_next = ea_x * ob_x;

    // align partial product and accumulate
    assign prod_ext = {{(AW-2*W-1){prod_reg[2*W]}}, prod_reg};
    always_comb
    begin
        case (s2_reg.chunk)
            2'd0:    shifted = prod_ext;
            2'd1:    shifted = prod_ext <<< W;
            2'd2:    shifted = prod_ext <<< (2 * W);
            default: shifted = prod_ext <<< (3 * W);
        endcase
    end
    assign addend   = s2_reg.neg ? -shifted : shifted;
    assign acc_next = (s2_reg.first ? '0 : acc_reg) + addend;

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
        end
        else
        begin
            s1_reg <= ctl0;
            s2_reg <= s1_reg;
        end
    end

    // product, accumulator and determinant
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (s2_reg.v)
        begin
            acc_reg <= acc_next;
            if (s2_reg.wr_det)
            begin
                det_reg <= acc_next[DTW-1:0];
            end
        end
    end

    m4inv_div #(
        .W   (W),
        .F   (F),
        .VW  (VW),
        .DTW (DTW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_go),
        .num   ($signed(w_rd_reg)),
        .den   (det_reg),
        .done  (div_done),
        .quot  (div_q),
        .sat   (div_sat)
    );

    assign status.det_zero = det_reg == '0;
    assign status.div_done = div_done;

    // result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            elem_out_reg <= cmd.emit_zero ? '0 : div_q;
            sat_reg      <= cmd.emit_zero ? 1'b0 : div_sat;
            sing_reg     <= cmd.emit_zero;
            pos_reg      <= cmd.pos;
            last_reg     <= cmd.pos == 4'd15;
        end
    end

    assign result_strobe = strobe_reg;
    assign element_out   = $signed(elem_out_reg);
    assign position      = pos_reg;
    assign last_element  = last_reg;
    assign singular      = sing_reg;
    assign saturated     = sat_reg;

endmodule

[rtl/core/m4inv_ctrl.sv]
// m4inv_ctrl: controller of the matrix inverter
// counts loaded items, steps the multiply-accumulate schedule and the divisions
// depends on m4inv_pkg
module m4inv_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    output m4inv_pkg::m4inv_cmd_t    cmd,
    input  m4inv_pkg::m4inv_status_t status
);
    import m4inv_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MAC   = 6'b000010,
        S_DRAIN = 6'b000100,
        S_DIVRD = 6'b001000,
        S_DIVGO = 6'b010000,
        S_DIVW  = 6'b100000
    } state_t;

    state_t       state_reg, state_next;
    m4inv_phase_t phase_reg, phase_next;
    logic [3:0]   idx_reg, idx_next;
    logic [1:0]   term_reg, term_next;
    logic [1:0]   chunk_reg, chunk_next;
    logic         drain_reg, drain_next;
    logic [3:0]   pos_reg, pos_next;
    logic [3:0]   load_reg, load_next;

    logic [1:0] chunk_max, term_max;
    logic [3:0] idx_max;

    // loop bounds of each phase
    always_comb
    begin
        unique case (phase_reg)
            PH_SC:
            begin
                chunk_max = 2'd0;
                term_max  = 2'd1;
                idx_max   = 4'd11;
            end
            PH_COF:
            begin
                chunk_max = 2'd1;
                term_max  = 2'd2;
                idx_max   = 4'd15;
            end
            PH_DET:
            begin
                chunk_max = 2'd3;
                term_max  = 2'd0;
                idx_max   = 4'd3;
            end
            default:
            begin
                chunk_max = 2'd0;
                term_max  = 2'd0;
                idx_max   = 4'd0;
            end
        endcase
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        term_next  = term_reg;
        chunk_next = chunk_reg;
        drain_next = drain_reg;
        pos_next   = pos_reg;
        load_next  = load_reg;

        cmd       = '0;
        cmd.phase = phase_reg;
        cmd.idx   = idx_reg;
        cmd.term  = term_reg;
        cmd.chunk = chunk_reg;
        cmd.pos   = pos_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd.idx = load_reg;
                if (start)
                begin
                    cmd.load  = 1'b1;
                    load_next = load_reg + 1'b1;
                    if (load_reg == 4'd15)
                    begin
                        state_next = S_MAC;
                        phase_next = PH_SC;
                        idx_next   = '0;
                        term_next  = '0;
                        chunk_next = '0;
                    end
                end
            end
            S_MAC:
            begin
                cmd.mac = 1'b1;
                if (chunk_reg != chunk_max)
                begin
                    chunk_next = chunk_reg + 1'b1;
                end
                else
                begin
                    chunk_next = '0;
                    if (term_reg != term_max)
                    begin
                        term_next = term_reg + 1'b1;
                    end
                    else
                    begin
                        term_next = '0;
                        if (idx_reg != idx_max)
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                        else
                        begin
                            idx_next   = '0;
                            drain_next = 1'b0;
                            state_next = S_DRAIN;
                        end
                    end
                end
            end
            S_DRAIN:
            begin
                // let the last writeback land before the next phase reads
                drain_next = 1'b1;
                if (drain_reg)
                begin
                    if (phase_reg == PH_DET)
                    begin
                        pos_next   = '0;
                        state_next = S_DIVRD;
                    end
                    else
                    begin
                        phase_next = (phase_reg == PH_SC) ? PH_COF : PH_DET;
                        state_next = S_MAC;
                    end
                end
            end
            S_DIVRD:
            begin
                cmd.rd_cof = 1'b1;
                state_next = S_DIVGO;
            end
            S_DIVGO:
            begin
                if (status.det_zero)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_zero = 1'b1;
                    pos_next      = pos_reg + 1'b1;
                    state_next    = (pos_reg == 4'd15) ? S_IDLE : S_DIVRD;
                end
                else
                begin
                    cmd.div_go = 1'b1;
                    state_next = S_DIVW;
                end
            end
            S_DIVW:
            begin
                if (status.div_done)
                begin
                    cmd.emit   = 1'b1;
                    pos_next   = pos_reg + 1'b1;
                    state_next = (pos_reg == 4'd15) ? S_IDLE : S_DIVRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_SC;
            idx_reg   <= '0;
            term_reg  <= '0;
            chunk_reg <= '0;
            drain_reg <= 1'b0;
            pos_reg   <= '0;
            load_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            term_reg  <= term_next;
            chunk_reg <= chunk_next;
            drain_reg <= drain_next;
            pos_reg   <= pos_next;
            load_reg  <= load_next;
        end
    end

    assign busy = state_reg != S_IDLE;

endmodule

[rtl/core/matrix4_inverse.sv]
// matrix4_inverse: 4x4 matrix inverse in signed fixed point, adjugate over determinant
// top level joining the controller and the datapath
// depends on m4inv_pkg, m4inv_ctrl, m4inv_dp
//
//  channel  | ports                                        | handshake
//  ---------+----------------------------------------------+----------------------
//  item in  | element_in                                   | start & !busy
//  item out | element_out, position, last_element,         | result_strobe, one
//           | singular, saturated                          | cycle, no back-pressure
//
// items one to fifteen of a matrix load in one cycle each; busy stays low
// the sixteenth item starts the work on one shared multiplier: 136
// multiply-accumulate steps (sub-determinants, adjugate, determinant) and
// three drains; then per element a read of its adjugate entry and a
// restoring division of that entry by the determinant
// a singular matrix gives its sixteen zero results without any division
// reset clears the load count and control; the result side never stalls
module matrix4_inverse #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] element_in,
    output logic                         result_strobe,
    output logic signed [DATA_WIDTH-1:0] element_out,
    output logic [3:0]                   position,
    output logic                         last_element,
    output logic                         singular,
    output logic                         saturated
);
    import m4inv_pkg::*;

    m4inv_cmd_t    cmd;
    m4inv_status_t status;

    // sequencer
    m4inv_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    // arithmetic and stores
    m4inv_dp #(
        .W (DATA_WIDTH),
        .F (FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .element_in    (element_in),
        .status        (status),
        .result_strobe (result_strobe),
        .element_out   (element_out),
        .position      (position),
        .last_element  (last_element),
        .singular      (singular),
        .saturated     (saturated)
    );

endmodule

[rtl/core/m4inv_chk.sv]
// m4inv_chk: port-level checks for the matrix inverter
// bound to matrix4_inverse; no package dependencies
module m4inv_chk #(
    parameter int DATA_WIDTH = 32
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  result_strobe,
    input logic [DATA_WIDTH-1:0] element_out,
    input logic [3:0]            position,
    input logic                  last_element,
    input logic                  singular,
    input logic                  saturated
);

    localparam logic [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // last flag marks position fifteen only
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> (last_element == (position == 4'd15)))
        else $error("last_element does not match position");

    // singular results are clean zeros
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && singular) |-> (element_out == '0 && !saturated))
        else $error("singular result not zero");

    // clipped results sit at a range limit
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && saturated) |-> (element_out == MAX_VAL || element_out == MIN_VAL))
        else $error("saturated result not at a limit");

    // block stays busy until the last result of a matrix
    a_busy_until_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !last_element) |-> busy)
        else $error("busy dropped before last result");

endmodule

bind matrix4_inverse m4inv_chk #(
    .DATA_WIDTH (DATA_WIDTH)
) u_m4inv_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .result_strobe (result_strobe),
    .element_out   (element_out),
    .position      (position),
    .last_element  (last_element),
    .singular      (singular),
    .saturated     (saturated)
);

[tb/matrix4_inverse_tb.sv]
// matrix4_inverse_tb: self-checking testbench for the 4x4 fixed-point matrix inverter
// loads whole matrices item by item and checks every inverse element against a predictor
// depends on matrix4_inverse only
module matrix4_inverse_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC       = 16;
    localparam int DW         = 32;
    localparam int QUIET_MAX  = 5000;
    localparam int SETTLE     = 200;

    typedef logic signed [191:0] wide_t;

    typedef struct {
        logic signed [DW-1:0] element;
        logic [3:0]           pos;
        logic                 last;
        logic                 sing;
        logic                 sat;
    } inv_elem_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic signed [DW-1:0] element_in;
    logic                 result_strobe;
    logic signed [DW-1:0] element_out;
    logic [3:0]           position;
    logic                 last_element;
    logic                 singular;
    logic                 saturated;

    inv_elem_t            inverse_q[$];
    logic signed [DW-1:0] shadow_matrix[16];
    int                   shadow_count;
    int                   errors;
    int                   quiet_cycles;

    matrix4_inverse #(.FRAC_BITS(FRAC), .DATA_WIDTH(DW)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .element_in(element_in), .result_strobe(result_strobe),
        .element_out(element_out), .position(position),
        .last_element(last_element), .singular(singular), .saturated(saturated)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // signed cofactor of entry (row, col)
    function automatic wide_t cofactor_of(input int row, input int col);
        int    rs[3];
        int    cs[3];
        int    n;
        wide_t e[3][3];
        wide_t r;
        n = 0;
        for (int k = 0; k < 4; k++)
            if (k != row)
            begin
                rs[n] = k;
                n++;
            end
        n = 0;
        for (int k = 0; k < 4; k++)
            if (k != col)
            begin
                cs[n] = k;
                n++;
            end
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                e[a][b] = wide_t'(shadow_matrix[rs[a] * 4 + cs[b]]);
        r = e[0][0] * (e[1][1] * e[2][2] - e[1][2] * e[2][1])
          - e[0][1] * (e[1][0] * e[2][2] - e[1][2] * e[2][0])
          + e[0][2] * (e[1][0] * e[2][1] - e[1][1] * e[2][0]);
        if ((row + col) % 2 == 1)
            r = -r;
        return r;
    endfunction

    // full inverse of the shadow matrix, rounded and saturated per element
    task automatic predict_inverse();
        wide_t       cof[16];
        wide_t       det;
        logic [191:0] num;
        logic [191:0] den;
        logic [191:0] quo;
        logic [191:0] rem;
        logic [191:0] lim;
        logic        neg;
        inv_elem_t   r;
        det = '0;
        for (int i = 0; i < 16; i++)
            cof[i] = cofactor_of(i / 4, i % 4);
        for (int c = 0; c < 4; c++)
            det = det + cof[c] * wide_t'(shadow_matrix[c]);
        for (int p = 0; p < 16; p++)
        begin
            r.pos  = p[3:0];
            r.last = (p == 15);
            r.sing = (det == 0);
            r.sat  = 1'b0;
            r.element = '0;
            if (det != 0)
            begin
                num = cof[(p % 4) * 4 + p / 4];
                neg = num[191] ^ det[191];
                if (num[191])
                    num = -num;
                den = det[191] ? -det : det;
                num = num << (2 * FRAC);
                quo = num / den;
                rem = num % den;
                if ((rem << 1) >= den)
                    quo = quo + 1;
                lim = (192'd1 << (DW - 1)) - (neg ? 0 : 1);
                if (quo > lim)
                begin
                    quo = lim;
                    r.sat = 1'b1;
                end
                r.element = neg ? -quo[DW-1:0] : quo[DW-1:0];
            end
            inverse_q.push_back(r);
        end
    endtask

    // send one item, wait for acceptance, update the shadow store
    task automatic send_item(input logic signed [DW-1:0] value);
        @(negedge clk);
        start      <= 1'b1;
        element_in <= value;
        do
            @(posedge clk);
        while (busy);
        shadow_matrix[shadow_count] = value;
        shadow_count = (shadow_count + 1) % 16;
        if (shadow_count == 0)
            predict_inverse();
    endtask

    // sender idle for a number of cycles
    task automatic idle_cycles(input int n);
        for (int i = 0; i < n; i++)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // wait until every expected result has come
    task automatic drain();
        idle_cycles(1);
        while (inverse_q.size() != 0)
            @(posedge clk);
    endtask

    // send a matrix with bursty gaps
    int burst_left = 0;
    task automatic send_matrix(input logic signed [DW-1:0] m[16]);
        for (int i = 0; i < 16; i++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                if ($urandom_range(0, 3) != 0)
                    idle_cycles($urandom_range(1, 6));
            end
            burst_left--;
            send_item(m[i]);
        end
    endtask

    // identity and a general invertible matrix
    task automatic test_identity();
        logic signed [DW-1:0] m[16];
        for (int i = 0; i < 16; i++)
            m[i] = (i % 5 == 0) ? 32'sh0001_0000 : '0;
        send_matrix(m);
        for (int i = 0; i < 16; i++)
            m[i] = (i % 5 == 0) ? 32'sh0002_0000 : 32'sh0000_4000;
        send_matrix(m);
        drain();
    endtask

    // zero determinant: all zero, and two equal rows
    task automatic test_singular();
        logic signed [DW-1:0] m[16];
        for (int i = 0; i < 16; i++)
            m[i] = '0;
        send_matrix(m);
        for (int i = 0; i < 16; i++)
            m[i] = (i >= 4 && i < 8) ? m[i - 4] : $signed($urandom());
        send_matrix(m);
        drain();
    endtask

    // extreme field values: tiny diagonal saturates, huge diagonal inverts to about +-2^-15, dense extremes
    task automatic test_extremes();
        logic signed [DW-1:0] m[16];
        for (int i = 0; i < 16; i++)
            m[i] = (i % 5 == 0) ? 32'sh0000_0001 : '0;
        send_matrix(m);
        for (int i = 0; i < 16; i++)
            m[i] = (i % 5 == 0) ? ((i < 8) ? 32'sh8000_0000 : 32'sh7fff_ffff) : '0;
        send_matrix(m);
        for (int i = 0; i < 16; i++)
            m[i] = (i % 2 == 0) ? 32'sh8000_0000 : 32'sh7fff_ffff;
        m[5] = 32'shffff_ffff;
        send_matrix(m);
        drain();
    endtask

    // random matrices of several kinds
    task automatic test_random();
        logic signed [DW-1:0] m[16];
        int kind;
        for (int n = 0; n < 9; n++)
        begin
            kind = $urandom_range(0, 5);
            for (int i = 0; i < 16; i++)
                case (kind)
                    0, 1:    m[i] = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
                    2:       m[i] = $signed($urandom());
                    3:       m[i] = (i % 5 == 0) ? $signed($urandom_range(1, 1 << 20))
                                                 : $signed($urandom_range(0, 255)) - 128;
                    4:       m[i] = $signed($urandom_range(0, 15)) - 8;
                    default: m[i] = $signed($urandom_range(0, 1 << 17)) - (1 << 16);
                endcase
            if (kind == 5)
                for (int c = 0; c < 4; c++)
                    m[12 + c] = m[c] + m[4 + c];
            send_matrix(m);
            if (n == 4)
                drain();
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        inv_elem_t exp_r;
        if (rst_n && result_strobe)
        begin
            if (inverse_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result at position %0d", $time, position);
            end
            else
            begin
                exp_r = inverse_q.pop_front();
                if (element_out !== exp_r.element || position !== exp_r.pos
                    || last_element !== exp_r.last || singular !== exp_r.sing
                    || saturated !== exp_r.sat)
                begin
                    errors++;
                    $display("%0t: mismatch expected elem=%h pos=%0d last=%b sing=%b sat=%b",
                             $time, exp_r.element, exp_r.pos, exp_r.last, exp_r.sing,
                             exp_r.sat);
                    $display("%0t:            actual elem=%h pos=%0d last=%b sing=%b sat=%b",
                             $time, element_out, position, last_element, singular,
                             saturated);
                end
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if ((start && !busy) || result_strobe)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_MAX)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        element_in   = '0;
        shadow_count = 0;
        errors       = 0;
        quiet_cycles = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_identity();
        test_singular();
        test_extremes();
        test_random();
        drain();
        idle_cycles(SETTLE);
        if (errors == 0 && inverse_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
